FILE: rtl/pmrc_pkg.sv
// Shared types and constants of the permuted mixed-radix counter.
`default_nettype none
package pmrc_pkg;

	localparam int TABLE_SLOTS = 8;
	localparam int RADIX_W     = 8;
	localparam int PERM_W      = 3;
	localparam int SLOT_W      = 3;
	localparam int COUNT_W     = 4;
	localparam int VALUE_W     = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 64;

	localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RADIX_TABLE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PERM_TABLE  = 2'd2;

	localparam logic [COUNT_W-1:0]                  DIGIT_COUNT_RST = 4'd1;
	localparam logic [TABLE_SLOTS*RADIX_W-1:0]      RADIX_TABLE_RST = 64'h0202020202020202;
	localparam logic [TABLE_SLOTS*PERM_W-1:0]       PERM_TABLE_RST  = 24'hFAC688;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INC,
		ST_WRAP,
		ST_VSTART,
		ST_MUL_D,
		ST_MUL_R,
		ST_LOAD
	} pmrc_state_t;

	typedef struct packed {
		logic accept;
		logic inc;
		logic wrap;
		logic vstart;
		logic mul_d;
		logic mul_r;
		logic load;
	} pmrc_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/pmrc_if.sv
// Request and response channel interfaces of the permuted mixed-radix counter.
`default_nettype none
interface pmrc_req_if;
	logic                                valid;
	logic                                ready;
	logic                                opcode;
	logic [pmrc_pkg::COUNT_W-1:0]        drop_count;

	modport source (output valid, output opcode, output drop_count, input ready);
	modport sink   (input valid, input opcode, input drop_count, output ready);
endinterface

interface pmrc_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [pmrc_pkg::VALUE_W-1:0]        value;
	logic                                wrapped;

	modport source (output valid, output value, output wrapped, input ready);
	modport sink   (input valid, input value, input wrapped, output ready);
endinterface
`default_nettype wire

FILE: rtl/pmrc_mul.sv
// Shared registered multiplier: low word of a 32-bit factor times a narrow operand.
`default_nettype none
module pmrc_mul #(
	parameter int B_W = 8
) (
	input  wire logic                         clk,
	input  wire logic [pmrc_pkg::VALUE_W-1:0] a,
	input  wire logic [B_W-1:0]               b,
	output logic      [pmrc_pkg::VALUE_W-1:0] prod
);

	logic [pmrc_pkg::VALUE_W+B_W-1:0] full;

	assign full = a * b;

	// keep the low word only, the value is taken modulo 2^32
	always_ff @(posedge clk) begin
		prod <= full[pmrc_pkg::VALUE_W-1:0];
	end

endmodule
`default_nettype wire

FILE: rtl/permuted_mixed_radix_counter_unit.sv
// Top level of the permuted mixed-radix counter: sequencer, digit store and output register.
`default_nettype none
// The unit holds a mixed-radix number of up to eight digits, each with its own radix from
// radix_table, and serves one request word at a time. Opcode 1 increments the number,
// walking the digits in permutation_table order and carrying while a digit reaches its
// radix; when every slot carries, digits 0..n-1 clear and the response word flags wrapped.
// Every request then returns the weighted value of digits drop_count..n-1 modulo 2^32.
// Steps: after acceptance an increment visits the slots in permutation order (1..n), with
// a wrap step if all carry, then a setup step, a digit and a radix step per digit kept (one
// shared 32-bit multiplier forms digit*factor, then factor*radix) and a load of the output
// register, which waits while the previous response word is not yet taken. The request
// side is ready only when the sequencer is idle; the output register lets the next
// request start while the previous response word still waits. Digits clear at reset, with
// no clearing pass. Configuration writes take effect at once; the user must make them only
// while the unit is idle, which the unit itself does not enforce.
module permuted_mixed_radix_counter_unit #(
	parameter int MAX_DIGITS = 8,
	parameter int DIGIT_BITS = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	pmrc_req_if.sink                                 req,
	pmrc_rsp_if.source                               rsp,
	input  wire logic                                cfg_we,
	input  wire logic [pmrc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [pmrc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int AW         = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int DIGIT_LIM  = (MAX_DIGITS < pmrc_pkg::TABLE_SLOTS) ?
	                            MAX_DIGITS : pmrc_pkg::TABLE_SLOTS;
	localparam int CW         = (DIGIT_BITS + 1 > pmrc_pkg::RADIX_W) ?
	                            DIGIT_BITS + 1 : pmrc_pkg::RADIX_W;
	localparam int MW         = (DIGIT_BITS > pmrc_pkg::RADIX_W) ?
	                            DIGIT_BITS : pmrc_pkg::RADIX_W;
	localparam logic [pmrc_pkg::COUNT_W-1:0] LIM = pmrc_pkg::COUNT_W'(DIGIT_LIM);

	// configuration registers
	logic [pmrc_pkg::COUNT_W-1:0]                               digit_count_q;
	logic [pmrc_pkg::TABLE_SLOTS*pmrc_pkg::RADIX_W-1:0]         radix_q;
	logic [pmrc_pkg::TABLE_SLOTS*pmrc_pkg::PERM_W-1:0]          perm_q;

	// sequencer and datapath
	pmrc_pkg::pmrc_state_t             state_q, state_nxt;
	pmrc_pkg::pmrc_ctrl_t              ctrl;
	logic [DIGIT_BITS-1:0]             digit_q [MAX_DIGITS];
	logic [pmrc_pkg::SLOT_W-1:0]       slot_q;
	logic [pmrc_pkg::SLOT_W-1:0]       i_q;
	logic [pmrc_pkg::COUNT_W-1:0]      drop_q;
	logic                              wrap_q;
	logic                              first_q;
	logic [pmrc_pkg::VALUE_W-1:0]      acc_q;
	logic [pmrc_pkg::VALUE_W-1:0]      factor_q;
	logic                              rsp_valid_q;
	logic [pmrc_pkg::VALUE_W-1:0]      out_value_q;
	logic                              out_wrapped_q;

	logic [pmrc_pkg::COUNT_W-1:0]      n_act;
	logic [pmrc_pkg::SLOT_W-1:0]       perm_map [pmrc_pkg::TABLE_SLOTS];
	logic [pmrc_pkg::PERM_W-1:0]       perm_idx;
	logic [pmrc_pkg::SLOT_W-1:0]       inc_d;
	logic [pmrc_pkg::SLOT_W-1:0]       rd_sel;
	logic [DIGIT_BITS-1:0]             rd_digit;
	logic [pmrc_pkg::RADIX_W-1:0]      rd_radix;
	logic [DIGIT_BITS:0]               inc_next;
	logic                              carry;
	logic                              last_slot;
	logic                              last_i;
	logic                              drop_ge_n;
	logic                              load_go;
	logic [pmrc_pkg::VALUE_W-1:0]      mul_a;
	logic [MW-1:0]                     mul_b;
	logic [pmrc_pkg::VALUE_W-1:0]      mul_p;

	// fold permutation indices onto the digits that exist
	for (genvar k = 0; k < pmrc_pkg::TABLE_SLOTS; k++) begin : g_perm_map
		assign perm_map[k] = pmrc_pkg::SLOT_W'(k % MAX_DIGITS);
	end

	// active digit count: zero acts as one, saturate at the digits that exist
	always_comb begin
		if (digit_count_q == '0) begin
			n_act = pmrc_pkg::COUNT_W'(1);
		end else if (digit_count_q > LIM) begin
			n_act = LIM;
		end else begin
			n_act = digit_count_q;
		end
	end

	assign perm_idx  = perm_q[pmrc_pkg::PERM_W*slot_q +: pmrc_pkg::PERM_W];
	assign inc_d     = perm_map[perm_idx];

	// one read port on the digit store: the slot's digit while incrementing, else digit i
	assign rd_sel    = (state_q == pmrc_pkg::ST_INC) ? inc_d : i_q;
	assign rd_digit  = digit_q[AW'(rd_sel)];
	assign rd_radix  = radix_q[pmrc_pkg::RADIX_W*rd_sel +: pmrc_pkg::RADIX_W];

	// carry when the bumped digit reaches its radix or overflows its width
	assign inc_next  = {1'b0, rd_digit} + (DIGIT_BITS+1)'(1);
	assign carry     = (CW'(inc_next) >= CW'(rd_radix)) || inc_next[DIGIT_BITS];

	assign last_slot = ({1'b0, slot_q} == (n_act - pmrc_pkg::COUNT_W'(1)));
	assign last_i    = ({1'b0, i_q} == (n_act - pmrc_pkg::COUNT_W'(1)));
	assign drop_ge_n = (drop_q >= n_act);
	assign load_go   = !rsp_valid_q || rsp.ready;

	// shared multiplier: digit times factor, then factor times radix
	assign mul_a = (state_q == pmrc_pkg::ST_MUL_D && first_q) ? pmrc_pkg::VALUE_W'(1) :
	               (state_q == pmrc_pkg::ST_MUL_D) ? mul_p : factor_q;
	assign mul_b = (state_q == pmrc_pkg::ST_MUL_R) ? MW'(rd_radix) : MW'(rd_digit);

	pmrc_mul #(
		.B_W (MW)
	) u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (mul_p)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			pmrc_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_nxt = req.opcode ? pmrc_pkg::ST_INC : pmrc_pkg::ST_VSTART;
				end
			end
			pmrc_pkg::ST_INC: begin
				if (!carry) begin
					state_nxt = pmrc_pkg::ST_VSTART;
				end else if (last_slot) begin
					state_nxt = pmrc_pkg::ST_WRAP;
				end
			end
			pmrc_pkg::ST_WRAP:   state_nxt = pmrc_pkg::ST_VSTART;
			pmrc_pkg::ST_VSTART: begin
				state_nxt = drop_ge_n ? pmrc_pkg::ST_LOAD : pmrc_pkg::ST_MUL_D;
			end
			pmrc_pkg::ST_MUL_D:  state_nxt = pmrc_pkg::ST_MUL_R;
			pmrc_pkg::ST_MUL_R: begin
				state_nxt = last_i ? pmrc_pkg::ST_LOAD : pmrc_pkg::ST_MUL_D;
			end
			pmrc_pkg::ST_LOAD: begin
				if (load_go) begin
					state_nxt = pmrc_pkg::ST_IDLE;
				end
			end
			default:             state_nxt = pmrc_pkg::ST_IDLE;
		endcase
	end

	// control strobes per state
	always_comb begin
		ctrl        = '0;
		ctrl.accept = (state_q == pmrc_pkg::ST_IDLE) && req.valid;
		ctrl.inc    = (state_q == pmrc_pkg::ST_INC);
		ctrl.wrap   = (state_q == pmrc_pkg::ST_WRAP);
		ctrl.vstart = (state_q == pmrc_pkg::ST_VSTART);
		ctrl.mul_d  = (state_q == pmrc_pkg::ST_MUL_D);
		ctrl.mul_r  = (state_q == pmrc_pkg::ST_MUL_R);
		ctrl.load   = (state_q == pmrc_pkg::ST_LOAD) && load_go;
	end

	assign req.ready   = (state_q == pmrc_pkg::ST_IDLE);
	assign rsp.valid   = rsp_valid_q;
	assign rsp.value   = out_value_q;
	assign rsp.wrapped = out_wrapped_q;

	// configuration registers; writes beyond the list drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= pmrc_pkg::DIGIT_COUNT_RST;
			radix_q       <= pmrc_pkg::RADIX_TABLE_RST;
			perm_q        <= pmrc_pkg::PERM_TABLE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pmrc_pkg::REG_DIGIT_COUNT: digit_count_q <= cfg_data[pmrc_pkg::COUNT_W-1:0];
				pmrc_pkg::REG_RADIX_TABLE: radix_q <= cfg_data;
				pmrc_pkg::REG_PERM_TABLE: begin
					perm_q <= cfg_data[pmrc_pkg::TABLE_SLOTS*pmrc_pkg::PERM_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pmrc_pkg::ST_IDLE;
			slot_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctrl.accept) begin
				slot_q <= '0;
			end else if (ctrl.inc) begin
				slot_q <= slot_q + pmrc_pkg::SLOT_W'(1);
			end
			// hold the response word until taken, refill from the sequencer
			if (ctrl.load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// digit store: one digit written per increment step, cleared in one go on wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_DIGITS; k++) begin
				digit_q[k] <= '0;
			end
		end else if (ctrl.inc) begin
			digit_q[AW'(inc_d)] <= carry ? '0 : inc_next[DIGIT_BITS-1:0];
		end else if (ctrl.wrap) begin
			for (int k = 0; k < MAX_DIGITS; k++) begin
				if (k < int'(n_act)) begin
					digit_q[k] <= '0;
				end
			end
		end
	end

	// value datapath
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			drop_q <= req.drop_count;
			wrap_q <= 1'b0;
		end
		if (ctrl.wrap) begin
			wrap_q <= 1'b1;
		end
		if (ctrl.vstart) begin
			i_q     <= drop_q[pmrc_pkg::SLOT_W-1:0];
			acc_q   <= '0;
			first_q <= 1'b1;
		end
		if (ctrl.mul_d) begin
			factor_q <= mul_a;
			first_q  <= 1'b0;
		end
		if (ctrl.mul_r) begin
			acc_q <= acc_q + mul_p;
			i_q   <= i_q + pmrc_pkg::SLOT_W'(1);
		end
		if (ctrl.load) begin
			out_value_q   <= acc_q;
			out_wrapped_q <= wrap_q;
		end
	end

`ifndef SYNTHESIS
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pmrc_pkg::ST_INC) |-> ({1'b0, slot_q} < n_act))
		else $error("increment walk past the active slots");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pmrc_pkg::ST_MUL_D || state_q == pmrc_pkg::ST_MUL_R) |->
		({1'b0, i_q} < n_act && {1'b0, i_q} >= drop_q))
		else $error("value digit index outside drop_count..n-1");

	a_wrap_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pmrc_pkg::ST_WRAP) |=> (digit_q[0] == '0 && wrap_q))
		else $error("wrap left digit zero set or flag clear");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |=> (rsp_valid_q && out_value_q == $past(acc_q)))
		else $error("response word not loaded from accumulator");
`endif

endmodule
`default_nettype wire
